FILE: src/sha256_byte_stream_hasher_assert.svh
// assertion macros used by the rtl file
`ifndef SHA256_BYTE_STREAM_HASHER_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASHER_ASSERT_SVH

// condition holds in the same cycle
`define SBH_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition holds in the next cycle
`define SBH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/sha256bsh_pkg.sv
package sha256bsh_pkg;

	localparam int unsigned WORD_W   = 32;
	localparam int unsigned ROUNDS   = 64;
	localparam int unsigned WIN_LEN  = 16;
	localparam int unsigned HASH_LEN = 8;
	localparam int unsigned COUNT_W  = 61;
	localparam int unsigned LEN_W    = 64;
	localparam int unsigned IDX_W    = 3;

	typedef logic [WORD_W-1:0] word_t;

	localparam logic [7:0] PAD_FIRST = 8'h80;
	localparam logic [7:0] PAD_ZERO  = 8'h00;
	localparam logic [5:0] LEN_POS   = 6'd56;
	localparam logic [5:0] LAST_POS  = 6'd63;
	localparam logic [5:0] LAST_RND  = 6'd63;
	localparam logic [IDX_W-1:0] LAST_IDX = 3'd7;

	localparam word_t ROUND_K [ROUNDS] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4f, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam word_t INIT_HASH [HASH_LEN] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic word_t big_sigma0(input word_t x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic word_t big_sigma1(input word_t x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic word_t small_sigma0(input word_t x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic word_t small_sigma1(input word_t x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

endpackage

FILE: src/sha256_byte_stream_hasher.sv
// channel   dir  tdata                            tuser      tlast
// s_axis    in   [7:0] data_byte                  has_data   last_byte
// m_axis    out  [31:0] digest_word, [34:32] idx  -          last_word
//
// a byte word is taken while idle; the 64th byte of a block starts a compression
// of 64 rounds plus a hash update, during which s_axis_tready is low. the round
// loop is one shared round datapath.
// end of message: 0x80, zero fill and 8 length bytes go in one per cycle, paused by
// rounds, then one or two compressions, then 8 digest words, one per m_axis handshake.
// arst_n resets the hash to its initial values and clears the byte count.
// a stalled m_axis holds the block; no new byte is taken until the digest is out.
`include "sha256_byte_stream_hasher_assert.svh"

module sha256_byte_stream_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tuser,   // [0] has_data
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index, rest zero
	output logic        m_axis_tlast
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LEN,
		ST_ROUND,
		ST_UPD,
		ST_OUT
	} state_t;

	state_t state_q;
	state_t ret_q;
	logic [5:0] pos_q;
	logic [5:0] round_q;
	logic [sha256bsh_pkg::COUNT_W-1:0] count_q;
	logic [sha256bsh_pkg::LEN_W-1:0] len_q;
	logic pad_first_q;
	logic [sha256bsh_pkg::IDX_W-1:0] idx_q;

	sha256bsh_pkg::word_t hash_q [sha256bsh_pkg::HASH_LEN];
	sha256bsh_pkg::word_t v_q [sha256bsh_pkg::HASH_LEN];
	sha256bsh_pkg::word_t w_q [sha256bsh_pkg::WIN_LEN];

	logic s_fire;
	logic m_fire;
	logic pad_to_len;
	logic shift_en;
	logic [7:0] shift_byte;
	logic comp_start;
	sha256bsh_pkg::word_t t1;
	sha256bsh_pkg::word_t t2;
	sha256bsh_pkg::word_t w_new;
	sha256bsh_pkg::word_t ch;
	sha256bsh_pkg::word_t mj;

	assign s_fire = s_axis_tvalid && s_axis_tready;
	assign m_fire = m_axis_tvalid && m_axis_tready;
	assign pad_to_len = (state_q == ST_PAD) && !pad_first_q && (pos_q == sha256bsh_pkg::LEN_POS);

	always_comb begin
		shift_en = 1'b0;
		shift_byte = sha256bsh_pkg::PAD_ZERO;
		unique case (state_q)
			ST_IDLE: begin
				shift_en = s_fire && s_axis_tuser;
				shift_byte = s_axis_tdata;
			end
			ST_PAD: begin
				shift_en = !pad_to_len;
				shift_byte = pad_first_q ? sha256bsh_pkg::PAD_FIRST : sha256bsh_pkg::PAD_ZERO;
			end
			ST_LEN: begin
				shift_en = 1'b1;
				shift_byte = len_q[63:56];
			end
			default: begin
				shift_en = 1'b0;
			end
		endcase
	end

	assign comp_start = shift_en && (pos_q == sha256bsh_pkg::LAST_POS);

	// one round of the compression and one step of the message schedule
	always_comb begin
		ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t1 = v_q[7] + sha256bsh_pkg::big_sigma1(v_q[4]) + ch
			+ sha256bsh_pkg::ROUND_K[round_q] + w_q[0];
		t2 = sha256bsh_pkg::big_sigma0(v_q[0]) + mj;
		w_new = w_q[0] + sha256bsh_pkg::small_sigma0(w_q[1]) + w_q[9]
			+ sha256bsh_pkg::small_sigma1(w_q[14]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q <= ST_IDLE;
			pos_q <= '0;
			round_q <= '0;
			count_q <= '0;
			len_q <= '0;
			pad_first_q <= 1'b0;
			idx_q <= '0;
		end else begin
			if (shift_en) begin
				pos_q <= pos_q + 6'd1;
			end
			if (comp_start) begin
				round_q <= '0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_fire) begin
						if (s_axis_tuser) begin
							count_q <= count_q + 1'b1;
						end
						if (s_axis_tlast) begin
							pad_first_q <= 1'b1;
						end
						if (comp_start) begin
							state_q <= ST_ROUND;
							ret_q <= s_axis_tlast ? ST_PAD : ST_IDLE;
						end else if (s_axis_tlast) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					if (pad_to_len) begin
						state_q <= ST_LEN;
						len_q <= {count_q, 3'b000};
					end else begin
						pad_first_q <= 1'b0;
						if (comp_start) begin
							state_q <= ST_ROUND;
							ret_q <= ST_PAD;
						end
					end
				end
				ST_LEN: begin
					len_q <= {len_q[55:0], 8'h00};
					if (comp_start) begin
						state_q <= ST_ROUND;
						ret_q <= ST_OUT;
					end
				end
				ST_ROUND: begin
					round_q <= round_q + 6'd1;
					if (round_q == sha256bsh_pkg::LAST_RND) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					state_q <= ret_q;
					idx_q <= '0;
				end
				ST_OUT: begin
					if (m_axis_tready) begin
						idx_q <= idx_q + 1'b1;
						if (idx_q == sha256bsh_pkg::LAST_IDX) begin
							state_q <= ST_IDLE;
							count_q <= '0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// hash state, rotated toward word 0 as the digest goes out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < sha256bsh_pkg::HASH_LEN; j++) begin
				hash_q[j] <= sha256bsh_pkg::INIT_HASH[j];
			end
		end else if (state_q == ST_UPD) begin
			for (int j = 0; j < sha256bsh_pkg::HASH_LEN; j++) begin
				hash_q[j] <= hash_q[j] + v_q[j];
			end
		end else if (m_fire) begin
			if (idx_q == sha256bsh_pkg::LAST_IDX) begin
				for (int j = 0; j < sha256bsh_pkg::HASH_LEN; j++) begin
					hash_q[j] <= sha256bsh_pkg::INIT_HASH[j];
				end
			end else begin
				for (int j = 0; j < sha256bsh_pkg::HASH_LEN - 1; j++) begin
					hash_q[j] <= hash_q[j + 1];
				end
				hash_q[sha256bsh_pkg::HASH_LEN-1] <= hash_q[0];
			end
		end
	end

	// block buffer doubles as the schedule window: bytes shift in, words shift out
	always_ff @(posedge clk) begin
		if (shift_en) begin
			for (int j = 0; j < sha256bsh_pkg::WIN_LEN - 1; j++) begin
				w_q[j] <= {w_q[j][23:0], w_q[j + 1][31:24]};
			end
			w_q[sha256bsh_pkg::WIN_LEN-1] <= {w_q[sha256bsh_pkg::WIN_LEN-1][23:0], shift_byte};
		end else if (state_q == ST_ROUND) begin
			for (int j = 0; j < sha256bsh_pkg::WIN_LEN - 1; j++) begin
				w_q[j] <= w_q[j + 1];
			end
			w_q[sha256bsh_pkg::WIN_LEN-1] <= w_new;
		end
	end

	always_ff @(posedge clk) begin
		if (comp_start) begin
			for (int j = 0; j < sha256bsh_pkg::HASH_LEN; j++) begin
				v_q[j] <= hash_q[j];
			end
		end else if (state_q == ST_ROUND) begin
			for (int j = 1; j < sha256bsh_pkg::HASH_LEN; j++) begin
				v_q[j] <= v_q[j - 1];
			end
			v_q[4] <= v_q[3] + t1;
			v_q[0] <= t1 + t2;
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = (state_q == ST_OUT);
	assign m_axis_tdata = {5'b00000, idx_q, hash_q[0]};
	assign m_axis_tlast = (idx_q == sha256bsh_pkg::LAST_IDX);

	`SBH_ASSERT_SAME(a_no_overlap, clk, arst_n, m_axis_tvalid, !s_axis_tready, "input taken while digest pending")
	`SBH_ASSERT_NEXT(a_block_full, clk, arst_n, comp_start, (state_q == ST_ROUND) && (round_q == 6'd0), "full block did not start rounds")
	`SBH_ASSERT_NEXT(a_rounds_end, clk, arst_n, (state_q == ST_ROUND) && (round_q == sha256bsh_pkg::LAST_RND), state_q == ST_UPD, "round count overran")
	`SBH_ASSERT_NEXT(a_len_align, clk, arst_n, pad_to_len, (state_q == ST_LEN) && (pos_q == sha256bsh_pkg::LEN_POS), "length not at byte 56")
	`SBH_ASSERT_NEXT(a_hash_init, clk, arst_n, m_fire && m_axis_tlast, s_axis_tready && (hash_q[0] == sha256bsh_pkg::INIT_HASH[0]) && (count_q == '0), "state not restored after digest")

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps

module tb;

	localparam int HOLD_CYCLES  = 400;
	localparam int RANDOM_WORDS = 320;
	localparam int IDLE_PCT     = 26;

	localparam logic [31:0] K_TAB [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4f, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] H_INIT [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last;
	} digest_beat_t;

	class digest_scoreboard;
		logic [31:0]  chain [8];
		logic [7:0]   blk [64];
		logic [60:0]  nbytes;
		digest_beat_t digest_q [$];
		int           mismatches;

		function new();
			foreach (blk[i])
				blk[i] = 8'h00;
			mismatches = 0;
			restart();
		endfunction

		function void restart();
			chain  = H_INIT;
			nbytes = '0;
		endfunction

		function logic [31:0] rotr(logic [31:0] x, int n);
			return (x >> n) | (x << (32 - n));
		endfunction

		function void compress();
			logic [31:0] w [16];
			logic [31:0] v [8];
			logic [31:0] nw, x15, x2, t1, t2;
			for (int i = 0; i < 16; i++)
				w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
			v = chain;
			for (int r = 0; r < 64; r++) begin
				if (r < 16) begin
					nw = w[r];
				end else begin
					// rolling 16-entry schedule window
					x15 = w[(r + 1) % 16];
					x2  = w[(r + 14) % 16];
					nw  = w[r % 16] + (rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3))
						+ w[(r + 9) % 16] + (rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10));
					w[r % 16] = nw;
				end
				t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
					+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[r] + nw;
				t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
					+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
				for (int j = 7; j > 0; j--)
					v[j] = v[j-1];
				v[4] = v[4] + t1;
				v[0] = t1 + t2;
			end
			for (int i = 0; i < 8; i++)
				chain[i] = chain[i] + v[i];
		endfunction

		function void note_word(logic [7:0] d, logic has, logic eom);
			int           pos;
			logic [63:0]  bitlen;
			digest_beat_t beat;
			if (has) begin
				blk[nbytes[5:0]] = d;
				nbytes = nbytes + 1'b1;
				if (nbytes[5:0] == 6'd0)
					compress();
			end
			if (!eom)
				return;
			pos = int'(nbytes[5:0]);
			blk[pos] = 8'h80;
			for (int i = pos + 1; i < 64; i++)
				blk[i] = 8'h00;
			// no room left for the length field, so it goes in an extra block
			if (pos >= 56) begin
				compress();
				foreach (blk[i])
					blk[i] = 8'h00;
			end
			bitlen = {nbytes, 3'b000};
			for (int i = 0; i < 8; i++)
				blk[63-i] = bitlen[8*i +: 8];
			compress();
			for (int i = 0; i < 8; i++) begin
				beat.word = chain[i];
				beat.idx  = 3'(i);
				beat.last = (i == 7);
				digest_q.push_back(beat);
			end
			restart();
		endfunction

		function void check_word(logic [31:0] w, logic [2:0] idx, logic lst);
			digest_beat_t want;
			if (digest_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected digest word %h idx %0d last %b", w, idx, lst);
				return;
			end
			want = digest_q.pop_front();
			if (w !== want.word || idx !== want.idx || lst !== want.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("digest mismatch: expected %h idx %0d last %b, got %h idx %0d last %b",
						want.word, want.idx, want.last, w, idx, lst);
			end
		endfunction

		function int pending();
			return digest_q.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;
	logic        s_axis_tuser = 1'b0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic        m_axis_tlast;

	// bumped by the sender, followed by the receiver
	int hold_count = 0;
	bit quiet = 1'b0;

	digest_scoreboard sb = new();

	sha256_byte_stream_hasher dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic put_word(input logic [7:0] d, input logic has, input logic eom);
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= d;
		s_axis_tuser  <= has;
		s_axis_tlast  <= eom;
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_word(d, has, eom);
	endtask

	task automatic send_message(input int len);
		bit joined;
		joined = (len > 0) && ($urandom_range(1) == 1);
		for (int i = 0; i < len; i++) begin
			// word without a byte or an end, the block should skip it
			if ($urandom_range(99) < 8)
				put_word(8'($urandom), 1'b0, 1'b0);
			put_word(8'($urandom), 1'b1, joined && (i == len - 1));
		end
		if (!joined)
			put_word(8'($urandom), 1'b0, 1'b1);
	endtask

	initial begin
		int sent, msg, len, sel;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		put_word(8'hff, 1'b0, 1'b0);
		put_word(8'h00, 1'b0, 1'b1);
		put_word(8'h61, 1'b1, 1'b0);
		put_word(8'h62, 1'b1, 1'b0);
		put_word(8'h63, 1'b1, 1'b1);
		put_word(8'h00, 1'b1, 1'b0);
		put_word(8'hff, 1'b1, 1'b0);
		put_word(8'ha5, 1'b0, 1'b1);
		put_word(8'hff, 1'b1, 1'b1);
		put_word(8'h00, 1'b0, 1'b0);
		put_word(8'h80, 1'b1, 1'b0);
		put_word(8'h7f, 1'b1, 1'b0);
		put_word(8'h01, 1'b1, 1'b1);

		sent = 0;
		msg  = 0;
		while (sent < RANDOM_WORDS) begin
			if (msg == 2)
				hold_count <= hold_count + 1;
			quiet <= (msg >= 4 && msg < 7);
			if (msg == 8) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
				while (sb.pending() != 0)
					@(posedge clk);
			end
			sel = $urandom_range(9);
			if (sel < 5)
				len = $urandom_range(8);
			else if (sel < 8)
				len = $urandom_range(66, 52);
			else if (sel == 8)
				len = $urandom_range(130, 118);
			else
				len = $urandom_range(40);
			send_message(len);
			sent += len + 1;
			msg++;
		end
		s_axis_tvalid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		int hold_seen, hold_left;
		hold_seen = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_word(m_axis_tdata[31:0], m_axis_tdata[34:32], m_axis_tlast);
			if (hold_count != hold_seen) begin
				hold_seen = hold_count;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	initial begin
		#2000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
